@@ design/utf8_to_c_wide_escape_unit_defines.svh @@
// Assertion helpers for the UTF-8 to C wide-string escape unit.
`ifndef UTF8_TO_C_WIDE_ESCAPE_UNIT_DEFINES_SVH
`define UTF8_TO_C_WIDE_ESCAPE_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define U8ESC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("u8esc: implication check failed");

// next-cycle implication, held off during reset
`define U8ESC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("u8esc: next-cycle check failed");

`endif

@@ design/u8esc_pkg.sv @@
// ----------------------------------------------------------------------------
// u8esc_pkg
// Shared types, character codes and the hex digit helper for the escape unit.
// ----------------------------------------------------------------------------
`default_nettype none

package u8esc_pkg;

    typedef enum logic [1:0] {
        JOB_CHAR = 2'd0,  // one character as is
        JOB_ESC  = 2'd1,  // backslash + one character
        JOB_U16  = 2'd2,  // \uXXXX
        JOB_SURR = 2'd3   // \uXXXX\uXXXX
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] v0;   // char in [7:0] for CHAR/ESC, first unit otherwise
        logic [15:0] v1;   // low surrogate
        logic        fin;  // job comes from the final byte of the string
    } job_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [3:0] LAST_CHAR = 4'd0;
    localparam logic [3:0] LAST_ESC  = 4'd1;
    localparam logic [3:0] LAST_U16  = 4'd5;
    localparam logic [3:0] LAST_SURR = 4'd11;

    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0] HI_SURR   = 16'hD800;
    localparam logic [15:0] LO_SURR   = 16'hDC00;

    // upper-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            hex_char = 8'h30 + {4'd0, n};
        end else begin
            hex_char = 8'h37 + {4'd0, n};
        end
    endfunction

endpackage

`default_nettype wire

@@ design/u8esc_front.sv @@
// ----------------------------------------------------------------------------
// u8esc_front
// Accepts source bytes, tracks the UTF-8 sequence state and turns each byte
// into an output job (or nothing, for a lead or continuation byte of a sequence that is not yet complete).
// ----------------------------------------------------------------------------
`default_nettype none

module u8esc_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_fin,
    output logic               push,
    output u8esc_pkg::job_t    job,
    output logic               pending
);

    logic        mode_reg;
    logic [20:0] acc_reg, acc_next;
    logic [1:0]  rem_reg, rem_next;

    logic [20:0] acc_cont;
    logic [1:0]  rem_dec;
    logic [20:0] start;
    logic [1:0]  more;
    logic        emit;
    logic        cp_emit;
    logic [20:0] cp;
    logic [20:0] supp;

    always_comb begin
        acc_cont = {acc_reg[14:0], in_byte[5:0]};
        rem_dec  = rem_reg - 2'd1;

        if (in_byte[7:5] == 3'b110) begin
            start = {16'd0, in_byte[4:0]};
            more  = 2'd1;
        end else if (in_byte[7:4] == 4'b1110) begin
            start = {17'd0, in_byte[3:0]};
            more  = 2'd2;
        end else if (in_byte[7:3] == 5'b11110) begin
            start = {18'd0, in_byte[2:0]};
            more  = 2'd3;
        end else begin
            start = {13'd0, in_byte};
            more  = 2'd0;
        end
    end

    always_comb begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        emit     = 1'b1;
        cp_emit  = 1'b0;
        cp       = start;
        job.kind = u8esc_pkg::JOB_CHAR;
        job.v0   = {8'd0, in_byte};
        job.v1   = '0;
        job.fin  = in_fin;

        if (rem_reg != 2'd0) begin
            cp = acc_cont;
            if (rem_dec == 2'd0 || in_fin) begin
                cp_emit  = 1'b1;
                acc_next = '0;
                rem_next = 2'd0;
            end else begin
                emit     = 1'b0;
                acc_next = acc_cont;
                rem_next = rem_dec;
            end
        end else if (in_byte == u8esc_pkg::CH_QUOTE || in_byte == u8esc_pkg::CH_BSLASH) begin
            job.kind = u8esc_pkg::JOB_ESC;
        end else if (in_byte == u8esc_pkg::CH_LF) begin
            job.kind = u8esc_pkg::JOB_ESC;
            job.v0   = {8'd0, u8esc_pkg::CH_N};
        end else if (in_byte == u8esc_pkg::CH_CR) begin
            job.kind = u8esc_pkg::JOB_ESC;
            job.v0   = {8'd0, u8esc_pkg::CH_R};
        end else if (in_byte == u8esc_pkg::CH_TAB) begin
            job.kind = u8esc_pkg::JOB_ESC;
            job.v0   = {8'd0, u8esc_pkg::CH_T};
        end else if (!in_byte[7] || !mode_reg) begin
            job.kind = u8esc_pkg::JOB_CHAR;
        end else if (more == 2'd0 || in_fin) begin
            // stray byte, or a lead byte that ends the string
            cp_emit  = 1'b1;
            acc_next = '0;
            rem_next = 2'd0;
        end else begin
            emit     = 1'b0;
            acc_next = start;
            rem_next = more;
        end

        supp = cp - u8esc_pkg::SUPP_BASE;

        if (cp_emit) begin
            if (cp[20:16] == 5'd0) begin
                job.kind = u8esc_pkg::JOB_U16;
                job.v0   = cp[15:0];
            end else begin
                job.kind = u8esc_pkg::JOB_SURR;
                job.v0   = u8esc_pkg::HI_SURR + {5'd0, supp[20:10]};
                job.v1   = u8esc_pkg::LO_SURR + {6'd0, supp[9:0]};
            end
        end
    end

    assign push    = accept && emit;
    assign pending = (rem_reg != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
            acc_reg  <= '0;
            rem_reg  <= 2'd0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (accept) begin
                acc_reg <= acc_next;
                rem_reg <= rem_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/u8esc_fifo.sv @@
// ----------------------------------------------------------------------------
// u8esc_fifo
// Short job queue between the byte classifier and the character emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module u8esc_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire u8esc_pkg::job_t push_job,
    input  wire logic            pop,
    output u8esc_pkg::job_t      head_job,
    output logic                 full,
    output logic                 empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    u8esc_pkg::job_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/u8esc_back.sv @@
// ----------------------------------------------------------------------------
// u8esc_back
// Walks the job at the queue head one character per cycle, while m_tready
// does not stall it, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module u8esc_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire u8esc_pkg::job_t head_job,
    input  wire logic            empty,
    output logic                 pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);

    logic [3:0]  idx_reg;
    logic        valid_reg;
    logic [7:0]  char_reg;
    logic        last_reg;
    logic        done_reg;

    logic        load;
    logic [3:0]  last_idx;
    logic        at_last;
    logic [2:0]  sub;
    logic [15:0] unit;
    logic [7:0]  ch;

    always_comb begin
        load = (!valid_reg || m_tready) && !empty;

        case (head_job.kind)
            u8esc_pkg::JOB_CHAR: last_idx = u8esc_pkg::LAST_CHAR;
            u8esc_pkg::JOB_ESC:  last_idx = u8esc_pkg::LAST_ESC;
            u8esc_pkg::JOB_U16:  last_idx = u8esc_pkg::LAST_U16;
            u8esc_pkg::JOB_SURR: last_idx = u8esc_pkg::LAST_SURR;
            default:             last_idx = u8esc_pkg::LAST_CHAR;
        endcase
        at_last = (idx_reg == last_idx);
        pop     = load && at_last;

        // second half of a surrogate pair starts at character six
        if (idx_reg >= 4'd6) begin
            sub  = 3'(idx_reg - 4'd6);
            unit = head_job.v1;
        end else begin
            sub  = idx_reg[2:0];
            unit = head_job.v0;
        end

        case (head_job.kind)
            u8esc_pkg::JOB_CHAR: ch = head_job.v0[7:0];
            u8esc_pkg::JOB_ESC:  ch = (idx_reg == 4'd0) ? u8esc_pkg::CH_BSLASH
                                                         : head_job.v0[7:0];
            default: begin
                case (sub)
                    3'd0:    ch = u8esc_pkg::CH_BSLASH;
                    3'd1:    ch = u8esc_pkg::CH_U;
                    3'd2:    ch = u8esc_pkg::hex_char(unit[15:12]);
                    3'd3:    ch = u8esc_pkg::hex_char(unit[11:8]);
                    3'd4:    ch = u8esc_pkg::hex_char(unit[7:4]);
                    default: ch = u8esc_pkg::hex_char(unit[3:0]);
                endcase
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= at_last ? 4'd0 : idx_reg + 4'd1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg <= ch;
            last_reg <= at_last;
            done_reg <= at_last && head_job.fin;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

endmodule

`default_nettype wire

@@ design/utf8_to_c_wide_escape_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_to_c_wide_escape_unit
// Streams a byte string into the body text of a C wide string literal.
// ----------------------------------------------------------------------------
// One source byte is taken per s_ transfer and gives 0 to 12 characters on the
// m_ side, one per cycle while m_tready is high: one for a plain character,
// two for a two-character escape, six for \uXXXX and twelve for a surrogate
// pair. The emitter sets the sustained rate, and a FIFO_DEPTH job queue lets
// input bytes keep flowing while a long escape drains or the output is
// stalled. Continuation bytes inside a UTF-8 sequence give no output until
// the sequence completes or the string ends. m_tlast marks the last character
// caused by one input byte and m_tuser the last character of the string.
// cfg_we/cfg_wdata set UTF-8 decoding (1, reset) or raw pass-through of high
// bytes (0); write it only while the unit is idle.
`default_nettype none
`include "utf8_to_c_wide_escape_unit_defines.svh"

module utf8_to_c_wide_escape_unit #(
    parameter int FIFO_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,   // utf8_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] byte_in
    input  wire logic        s_tlast,     // final_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,     // [7:0] char_out
    output logic             m_tlast,     // last_of_run
    output logic             m_tuser      // [0] string_done
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    logic            pending;
    u8esc_pkg::job_t push_job;
    u8esc_pkg::job_t head_job;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    u8esc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_byte   (s_tdata),
        .in_fin    (s_tlast),
        .push      (push),
        .job       (push_job),
        .pending   (pending)
    );

    u8esc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (full),
        .empty    (empty)
    );

    u8esc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // end of string always closes a run
    `U8ESC_ASSERT_IMP(a_done_is_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast)
    // a final byte leaves no UTF-8 sequence open
    `U8ESC_ASSERT_NXT(a_final_clears, aclk, aresetn, accept && s_tlast, !pending)
    // a final byte always queues a job
    `U8ESC_ASSERT_IMP(a_final_pushes, aclk, aresetn, accept && s_tlast, push)
    // the emitter only retires a job that is present
    `U8ESC_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, pop, !empty)

endmodule

`default_nettype wire
